// ===== hw/rtl/ltc_pkg.sv =====
// Package for the lexical token classifier: token codes, constants, helpers.
// Used by all modules in hw/rtl; no dependencies.
package ltc_pkg;

	localparam int SymbolTableDepth = 64;
	localparam int MaxLexemeChars = 8;
	localparam int QueueDepth = 4;

	typedef enum logic [1:0] {
		KIND_NUMBER  = 2'd0,
		KIND_KEYWORD = 2'd1,
		KIND_IDENT   = 2'd2,
		KIND_SYMBOL  = 2'd3
	} token_kind_t;

	localparam logic [7:0] CharLf    = 8'd10;
	localparam logic [7:0] CharSlash = 8'h2f;
	localparam logic [7:0] CharStar  = 8'h2a;
	localparam logic [7:0] CharDot   = 8'h2e;
	localparam logic [7:0] CharUnder = 8'h5f;

	// one classified character going from front to back
	typedef struct packed {
		logic [7:0] ch;
		logic       last_of_line;
	} char_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_CLASSIFY,
		BK_SEARCH,
		BK_NUM,
		BK_WORD,
		BK_SYM
	} back_state_t;

	typedef struct packed {
		token_kind_t kind;
		logic [6:0]  attribute;
		logic [2:0]  declared_type;
		logic [63:0] text;
		logic [7:0]  length;
		logic        table_full;
	} token_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// index of special symbol, valid flag in bit 3
	function automatic logic [3:0] symbol_code(input logic [7:0] c);
		case (c)
			8'h23: return 4'b1000;
			8'h28: return 4'b1001;
			8'h29: return 4'b1010;
			8'h3b: return 4'b1011;
			8'h3c: return 4'b1100;
			8'h3e: return 4'b1101;
			8'h3d: return 4'b1110;
			default: return 4'b0000;
		endcase
	endfunction

	// keyword match on the kept characters (mask m): bit 3 valid, bits 2:0 index
	function automatic logic [3:0] keyword_code(input logic [63:0] t, input logic [7:0] n,
	                                            input logic [63:0] m);
		if (n == 8'd3 && t == (64'h0000_0000_0074_6e69 & m)) return 4'b1000;
		if (n == 8'd5 && t == (64'h0000_0074_616f_6c66 & m)) return 4'b1001;
		if (n == 8'd4 && t == (64'h0000_0000_6469_6f76 & m)) return 4'b1010;
		if (n == 8'd2 && t == (64'h0000_0000_0000_6669 & m)) return 4'b1011;
		if (n == 8'd4 && t == (64'h0000_0000_6573_6c65 & m)) return 4'b1100;
		return 4'b0000;
	endfunction

endpackage

// ===== hw/rtl/lexical_token_classifier.sv =====
// Top level of the lexical token classifier.
// Depends on ltc_pkg, ltc_front, ltc_queue, ltc_back.
// A source byte is taken in any cycle in which the four-entry queue has room; bytes removed as
// comments push nothing. The back end loads each queued character; one that extends a word
// or number returns the back end to idle, while a delimiter or line end goes on through
// classify, a search of the stored table entries in the name memory when an identifier
// candidate needs one, and the number, word and symbol output states, which stall while a
// token waits for out_ready. last_of_run is set on the final token caused by each character.
module lexical_token_classifier import ltc_pkg::*; #(
	parameter int SYMBOL_TABLE_DEPTH = SymbolTableDepth,
	parameter int MAX_LEXEME_CHARS = MaxLexemeChars
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  source_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  token_kind,
	output logic [6:0]  attribute,
	output logic [2:0]  declared_type,
	output logic [63:0] lexeme_text,
	output logic [7:0]  lexeme_length,
	output logic        table_full,
	output logic        last_of_run
);

	logic       push, room, not_empty, pop;
	char_item_t push_item, head;
	token_t     tok;

	ltc_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_byte(source_byte),
		.push, .push_item, .queue_room(room)
	);

	ltc_queue u_queue (
		.clk, .arst_n, .push, .push_item, .room, .not_empty, .head, .pop
	);

	ltc_back #(.TableDepth(SYMBOL_TABLE_DEPTH), .MaxChars(MAX_LEXEME_CHARS)) u_back (
		.clk, .arst_n, .q_not_empty(not_empty), .q_head(head), .q_pop(pop),
		.out_valid, .out_ready, .out_tok(tok), .out_last(last_of_run)
	);

	assign token_kind = tok.kind;
	assign attribute = tok.attribute;
	assign declared_type = tok.declared_type;
	assign lexeme_text = tok.text;
	assign lexeme_length = tok.length;
	assign table_full = tok.table_full;

endmodule

// ===== hw/rtl/ltc_front.sv =====
// Front end: comment stripping with one-byte lookahead.
// Depends on ltc_pkg; feeds ltc_queue.
module ltc_front import ltc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       push,
	output char_item_t push_item,
	input  logic       queue_room
);

	logic       block_q, held_valid_q, dropped_q;
	logic [7:0] held_q;
	logic       is_lf, pass_held, take;

	assign in_ready = queue_room;
	assign take = in_valid && in_ready;
	assign is_lf = (in_byte == CharLf);

	// held byte passes on when it forms no pair
	always_comb begin
		pass_held = 1'b0;
		if (is_lf) begin
			pass_held = held_valid_q && !dropped_q && !block_q;
		end else if (!dropped_q && held_valid_q) begin
			if (!((held_q == CharSlash && (in_byte == CharSlash || in_byte == CharStar)) ||
			      (held_q == CharStar && in_byte == CharSlash)))
				pass_held = !block_q;
		end
	end

	// on line end push one item: the held byte if it passes, else a zero byte;
	// the back end flushes its buffers after that character
	assign push = take && (is_lf || pass_held);
	assign push_item.ch = pass_held ? held_q : 8'd0;
	assign push_item.last_of_line = is_lf;

	// update lookahead and comment marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= 1'b0;
			held_valid_q <= 1'b0;
			dropped_q <= 1'b0;
			held_q <= 8'd0;
		end else if (take) begin
			if (is_lf) begin
				held_valid_q <= 1'b0;
				held_q <= 8'd0;
				dropped_q <= 1'b0;
			end else if (!dropped_q) begin
				if (!held_valid_q) begin
					held_q <= in_byte;
					held_valid_q <= 1'b1;
				end else if (held_q == CharSlash && in_byte == CharSlash) begin
					dropped_q <= 1'b1;
					held_valid_q <= 1'b0;
				end else if (held_q == CharSlash && in_byte == CharStar) begin
					block_q <= 1'b1;
					held_valid_q <= 1'b0;
				end else if (held_q == CharStar && in_byte == CharSlash) begin
					block_q <= 1'b0;
					held_valid_q <= 1'b0;
				end else begin
					held_q <= in_byte;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/ltc_queue.sv =====
// Short FIFO between front and back ends.
// Depends on ltc_pkg.
module ltc_queue import ltc_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  char_item_t push_item,
	output logic       room,
	output logic       not_empty,
	output char_item_t head,
	input  logic       pop
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	char_item_t       mem_q [Depth];
	logic [AW-1:0]    rd_q, wr_q;
	logic [AW:0]      cnt_q;

	assign room = (cnt_q < (AW + 1)'(Depth));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW + 1)'(push) - (AW + 1)'(pop);
		end
	end

endmodule

// ===== hw/rtl/ltc_back.sv =====
// Back end: lexeme buffers, keyword match, symbol table search, token output.
// Depends on ltc_pkg; reads from ltc_queue.
module ltc_back import ltc_pkg::*; #(
	parameter int TableDepth = SymbolTableDepth,
	parameter int MaxChars = MaxLexemeChars
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  char_item_t  q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output token_t      out_tok,
	output logic        out_last
);

	localparam int TW = $clog2(TableDepth + 1);
	localparam int IW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam logic [63:0] TextMask = (MaxChars >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * MaxChars)) - 64'd1);

	back_state_t   state_q, state_d;
	char_item_t    cur_q;
	logic [63:0]   word_q, num_q;
	logic [7:0]    wlen_q, nlen_q;
	logic          dot_q, ltv_q;
	logic [2:0]    lti_q;
	logic [TW-1:0] count_q, scan_q;
	logic [63:0]   names_mem [TableDepth];
	logic [63:0]   rd_data_q;
	logic          rd_ok_q;
	token_t        word_tok_q;
	logic          word_emit_q;
	token_t        tok_q;
	logic          tok_valid_q, tok_last_q;

	logic [7:0]    c;
	logic          line_end, joins_word, joins_num;
	logic [3:0]    kw, sc;
	logic          out_free, hit, store, emit, mem_re, run_done;
	token_t        emit_tok;
	logic          emit_last;

	function automatic logic [63:0] put_char(input logic [63:0] t, input logic [7:0] n,
	                                         input logic [7:0] ch);
		logic [63:0] r;
		r = t;
		if (n < 8'(MaxChars)) r[n[2:0]*8 +: 8] = ch;
		return r;
	endfunction

	assign out_valid = tok_valid_q;
	assign out_tok = tok_q;
	assign out_last = tok_last_q;

	assign c = cur_q.ch;
	assign line_end = cur_q.last_of_line;
	assign joins_word = is_letter(c) || (wlen_q != 8'd0 && (is_digit(c) || c == CharUnder));
	assign joins_num = is_digit(c) || c == CharDot;
	assign kw = keyword_code(word_q, wlen_q, TextMask);
	assign sc = symbol_code(c);
	assign out_free = !tok_valid_q || out_ready;
	assign hit = rd_ok_q && (rd_data_q == word_q);
	assign q_pop = (state_q == BK_IDLE) && q_not_empty;
	assign run_done = (state_q == BK_SYM) && (state_d == BK_IDLE);

	// next state, table strobes and the token offered this cycle
	always_comb begin
		state_d = state_q;
		mem_re = 1'b0;
		store = 1'b0;
		emit = 1'b0;
		emit_tok = word_tok_q;
		emit_last = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_not_empty) state_d = BK_LOAD;
			end
			BK_LOAD: begin
				if (!(joins_word || joins_num) || line_end) state_d = BK_CLASSIFY;
				else state_d = BK_IDLE;
			end
			BK_CLASSIFY: begin
				if (wlen_q == 8'd0 || kw[3] || !ltv_q) begin
					state_d = BK_NUM;
				end else if (count_q == '0) begin
					store = 1'b1;
					state_d = BK_NUM;
				end else begin
					state_d = BK_SEARCH;
				end
			end
			BK_SEARCH: begin
				if (hit) begin
					state_d = BK_NUM;
				end else if (scan_q < count_q) begin
					mem_re = 1'b1;
				end else begin
					store = 1'b1;
					state_d = BK_NUM;
				end
			end
			BK_NUM: begin
				emit_tok = '{KIND_NUMBER, {6'd0, dot_q}, 3'd0, num_q, nlen_q, 1'b0};
				emit_last = !word_emit_q && !sc[3];
				if (nlen_q == 8'd0) begin
					state_d = BK_WORD;
				end else if (out_free) begin
					emit = 1'b1;
					state_d = BK_WORD;
				end
			end
			BK_WORD: begin
				emit_tok = word_tok_q;
				emit_last = !sc[3];
				if (!word_emit_q) begin
					state_d = BK_SYM;
				end else if (out_free) begin
					emit = 1'b1;
					state_d = BK_SYM;
				end
			end
			BK_SYM: begin
				emit_tok = '{KIND_SYMBOL, {4'd0, sc[2:0]}, 3'd0, {56'd0, c}, 8'd1, 1'b0};
				emit_last = 1'b1;
				if (!sc[3]) begin
					state_d = BK_IDLE;
				end else if (out_free) begin
					emit = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// advance the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// take characters, build lexemes, step the search address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			word_q <= '0; wlen_q <= '0;
			num_q <= '0; nlen_q <= '0; dot_q <= 1'b0;
			scan_q <= '0; rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= mem_re;
			if (q_pop) cur_q <= q_head;
			if (state_q == BK_CLASSIFY) scan_q <= '0;
			else if (mem_re) scan_q <= scan_q + 1'b1;
			if (state_q == BK_LOAD && joins_word) begin
				word_q <= put_char(word_q, wlen_q, c);
				if (wlen_q != 8'd255) wlen_q <= wlen_q + 8'd1;
			end else if (run_done) begin
				word_q <= '0; wlen_q <= '0;
			end
			if (state_q == BK_LOAD && joins_num && !joins_word) begin
				num_q <= put_char(num_q, nlen_q, c);
				if (nlen_q != 8'd255) nlen_q <= nlen_q + 8'd1;
				if (c == CharDot) dot_q <= 1'b1;
			end else if (run_done) begin
				num_q <= '0; nlen_q <= '0; dot_q <= 1'b0;
			end
		end
	end

	// resolve the word at a delimiter: keyword, new identifier, or nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_emit_q <= 1'b0; word_tok_q <= '0; count_q <= '0;
			ltv_q <= 1'b0; lti_q <= '0;
		end else if (state_q == BK_CLASSIFY && wlen_q != 8'd0 && kw[3]) begin
			word_emit_q <= 1'b1;
			word_tok_q <= '{KIND_KEYWORD, {4'd0, kw[2:0]}, 3'd0, word_q, wlen_q, 1'b0};
			ltv_q <= 1'b1; lti_q <= kw[2:0];
		end else if (store) begin
			word_emit_q <= 1'b1;
			if (count_q < TW'(TableDepth)) begin
				word_tok_q <= '{KIND_IDENT, 7'(count_q + 1'b1), lti_q, word_q, wlen_q, 1'b0};
				count_q <= count_q + 1'b1;
			end else begin
				word_tok_q <= '{KIND_IDENT, 7'd0, lti_q, word_q, wlen_q, 1'b1};
			end
		end else if (state_q == BK_CLASSIFY || (state_q == BK_SEARCH && hit)) begin
			word_emit_q <= 1'b0;
		end else if (run_done && line_end) begin
			ltv_q <= 1'b0; lti_q <= '0;
		end
	end

	// name memory: store a new name, registered read for the search
	always_ff @(posedge clk) begin
		if (store && count_q < TW'(TableDepth)) names_mem[count_q[IW-1:0]] <= word_q;
		if (mem_re) rd_data_q <= names_mem[scan_q[IW-1:0]];
	end

	// output register: load a token, drop it after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
			tok_q <= '0;
			tok_last_q <= 1'b0;
		end else if (emit) begin
			tok_valid_q <= 1'b1;
			tok_q <= emit_tok;
			tok_last_q <= emit_last;
		end else if (out_ready) begin
			tok_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/ltc_checker.sv =====
// Port-level checker for the lexical token classifier, bound to the top level.
// Depends on ltc_pkg.
module ltc_checker import ltc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] token_kind,
	input logic [6:0] attribute,
	input logic       table_full,
	input logic [7:0] lexeme_length
);

	// hold a stalled transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

	// symbols are one character
	a_sym_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_SYMBOL |-> lexeme_length == 8'd1)
		else $error("symbol length");

	// full flag only on unstored identifiers
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> token_kind == KIND_IDENT && attribute == 7'd0)
		else $error("full flag");

	// numbers carry int or float only
	a_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_NUMBER |-> attribute <= 7'd1)
		else $error("number attribute");

endmodule

bind lexical_token_classifier ltc_checker u_ltc_checker (
	.clk, .arst_n, .out_valid, .out_ready, .token_kind, .attribute, .table_full,
	.lexeme_length
);
